[rtl/core/hls_pkg.sv]
// Shared types, constants and functions of the hopping link supervisor.
// Used by hls_step and hopping_link_supervisor; depends on nothing else.
package hls_pkg;

  localparam int HOP_COUNT = 47;
  localparam int HopW      = 6;
  localparam int CfgAddrW  = 2;
  localparam int CfgDataW  = 16;

  localparam logic [7:0]  SLOT_MS_RST      = 8'd9;
  localparam logic [15:0] LOST_WAIT_RST    = 16'd500;
  localparam logic [7:0]  STATS_WINDOW_RST = 8'd50;
  localparam logic [15:0] SLOT_TIMER_RST   = 16'd500;
  localparam logic [7:0]  RSSI_RST         = 8'd100;

  localparam logic [4:0]  RSSI_GAIN   = 5'd18;
  localparam int          RSSI_SHIFT  = 5;
  localparam logic [7:0]  RSSI_OFS_HI = 8'd82;
  localparam logic [7:0]  RSSI_OFS_LO = 8'd65;

  localparam logic [1:0]  TEL_PHASE = 2'd2;

  typedef enum logic [CfgAddrW-1:0] {
    REG_SLOT_MS      = 2'd0,
    REG_LOST_WAIT_MS = 2'd1,
    REG_STATS_WINDOW = 2'd2
  } reg_idx_e;

  typedef enum logic {
    CMD_TICK   = 1'b0,
    CMD_PACKET = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [7:0]  slot_ms;
    logic [15:0] lost_wait_ms;
    logic [7:0]  stats_window;
  } cfg_t;

  typedef struct packed {
    logic [15:0]     slot_timer;
    logic [HopW-1:0] hop_idx;
    logic            got_packet;
    logic            lost_flag;
    logic [7:0]      hop_counter;
    logic [7:0]      rx_counter;
    logic [7:0]      quality;
    logic [7:0]      rssi;
  } state_t;

  typedef struct packed {
    logic       cmd;
    logic       packet_valid;
    logic [7:0] frame_counter;
    logic [7:0] request_id;
    logic [7:0] rssi_byte;
  } item_t;

  // Declared from the top bit down so that the packed word matches the
  // stream data layout, current_hop in the lowest bits.
  typedef struct packed {
    logic            packet_accepted;
    logic [7:0]      tlm_id;
    logic            tlm_req;
    logic [7:0]      rssi_out;
    logic [7:0]      link_quality;
    logic            link_lost;
    logic            enter_failsafe;
    logic            frame_lost;
    logic            switch_antenna;
    logic            hopped;
    logic [HopW-1:0] current_hop;
  } result_t;

  localparam int ResultW = $bits(result_t);
  localparam int OutDataW = ((ResultW + 7) / 8) * 8;

  // Scales the raw status byte and moves it to the wrapping 8-bit form.
  function automatic logic [7:0] convert_rssi(input logic [7:0] raw);
    logic [12:0] prod;
    logic [7:0]  t;
    prod = {5'b0, raw} * {8'b0, RSSI_GAIN};
    t    = 8'(prod >> RSSI_SHIFT);
    if (raw[7]) begin
      return t - RSSI_OFS_HI;
    end
    return t + RSSI_OFS_LO;
  endfunction

endpackage

[rtl/core/hls_step.sv]
// Next-state and result logic of the hopping link supervisor for one item.
// Purely combinational; uses types and functions from hls_pkg.
module hls_step #(
  parameter int HopCount = hls_pkg::HOP_COUNT
) (
  input  hls_pkg::cfg_t    cfg_i,
  input  hls_pkg::state_t  state_i,
  input  hls_pkg::item_t   item_i,
  output hls_pkg::state_t  state_o,
  output hls_pkg::result_t result_o
);

  logic                     is_tick;
  logic                     pkt_ok;
  logic                     tel;
  logic [15:0]              timer_dec;
  logic                     slot_end;
  logic                     advance;
  logic [hls_pkg::HopW:0]   hop_inc;
  logic [hls_pkg::HopW-1:0] hop_next;
  logic                     lost_pre;
  logic                     got_pre;
  logic [7:0]               rx_pre;
  logic                     win_close;
  logic                     no_rx;

  always_comb begin
    is_tick  = (item_i.cmd == hls_pkg::CMD_TICK);
    pkt_ok   = (item_i.cmd == hls_pkg::CMD_PACKET) && item_i.packet_valid;
    tel      = pkt_ok && (item_i.frame_counter[1:0] == hls_pkg::TEL_PHASE);
    timer_dec = state_i.slot_timer - {15'b0, (state_i.slot_timer != 16'd0)};
    slot_end = (is_tick && (timer_dec == 16'd0)) || (pkt_ok && !tel);
    advance  = slot_end || tel;

    hop_inc  = {1'b0, state_i.hop_idx} + 7'd1;
    hop_next = (hop_inc >= 7'(HopCount)) ? '0 : hop_inc[hls_pkg::HopW-1:0];

    // A valid packet takes effect before any slot end that it causes.
    lost_pre = pkt_ok ? 1'b0 : state_i.lost_flag;
    got_pre  = pkt_ok ? 1'b1 : state_i.got_packet;
    rx_pre   = pkt_ok ? state_i.rx_counter + 8'd1 : state_i.rx_counter;
    win_close = (state_i.hop_counter >= cfg_i.stats_window);
    no_rx    = (rx_pre == 8'd0);

    state_o            = state_i;
    state_o.got_packet = got_pre;
    state_o.lost_flag  = lost_pre;
    state_o.rx_counter = rx_pre;
    if (pkt_ok) begin
      state_o.rssi = hls_pkg::convert_rssi(item_i.rssi_byte);
    end
    if (is_tick) begin
      state_o.slot_timer = timer_dec;
    end
    if (tel) begin
      state_o.slot_timer = {8'b0, cfg_i.slot_ms};
    end
    if (advance) begin
      state_o.hop_idx = hop_next;
    end
    if (slot_end) begin
      state_o.slot_timer  = lost_pre ? cfg_i.lost_wait_ms : {8'b0, cfg_i.slot_ms};
      state_o.got_packet  = 1'b0;
      state_o.hop_counter = state_i.hop_counter + 8'd1;
      if (win_close) begin
        state_o.quality     = rx_pre;
        state_o.lost_flag   = lost_pre || no_rx;
        state_o.hop_counter = 8'd1;
        state_o.rx_counter  = 8'd0;
      end
    end

    result_o.current_hop     = state_o.hop_idx;
    result_o.hopped          = advance;
    result_o.switch_antenna  = slot_end && !got_pre;
    result_o.frame_lost      = slot_end && !got_pre;
    result_o.enter_failsafe  = slot_end && win_close && no_rx;
    result_o.link_lost       = state_o.lost_flag;
    result_o.link_quality    = state_o.quality;
    result_o.rssi_out        = state_o.rssi;
    result_o.tlm_req         = tel;
    result_o.tlm_id          = tel ? item_i.request_id : 8'd0;
    result_o.packet_accepted = pkt_ok;
  end

endmodule

[rtl/core/hopping_link_supervisor.sv]
// Top level of the hopping link supervisor: stream ports, configuration
// registers, link state and the result register. Uses hls_pkg and hls_step.
//
// The supervisor follows a frequency-hopping radio link. Each input word is
// either a one-millisecond tick (tuser bit 0 low) or a report of a received
// packet (tuser bit 0 high, tuser bit 1 saying whether the packet passed its
// checks). Every input word yields exactly one result word. The block takes
// one word per clock cycle while the output is not stalled: the link state
// is updated at the edge that accepts a word, and that word's result is
// loaded into the output register at the same edge. That register is the
// only buffering, so the input is ready whenever it is empty or is being
// emptied in the same cycle; a stalled output holds off the input stream.
// Ticks count the slot timer down; at the end of a slot the hop index
// advances modulo HopCount, the timer reloads with the slot length while the
// link is up or the lost dwell while it is down, a slot without a packet
// raises the antenna-switch and lost-frame flags, and every statistics
// window the packet count is published as link quality, a zero count
// declaring the link lost and entering failsafe. A valid packet converts the
// RSSI byte and either closes the slot at once or, on a telemetry frame,
// hops at once and requests telemetry. Configuration is written through a
// plain write port; the user must write it only while the block is idle,
// which the block does not enforce. Writes to an unused index are ignored.
module hopping_link_supervisor #(
  parameter int HopCount = hls_pkg::HOP_COUNT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [hls_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [hls_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // Input stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [7:0] frame_counter, [15:8] request_id, [23:16] rssi_byte
  input  logic [23:0]                   s_axis_tdata_i,
  // [0] cmd, [1] packet_valid
  input  logic [1:0]                    s_axis_tuser_i,
  // Output stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [5:0] current_hop, [6] hopped, [7] switch_antenna, [8] frame_lost,
  // [9] enter_failsafe, [10] link_lost, [18:11] link_quality,
  // [26:19] rssi_out, [27] tlm_req, [35:28] tlm_id,
  // [36] packet_accepted, [39:37] zero
  output logic [hls_pkg::OutDataW-1:0]  m_axis_tdata_o
);

  hls_pkg::cfg_t    cfg_q;
  hls_pkg::state_t  state_q, state_d;
  hls_pkg::item_t   item;
  hls_pkg::result_t result_d, result_q;
  logic             out_valid_q;
  logic             in_accept;

  // The output register frees up in the same cycle as it is read.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  assign item.cmd           = s_axis_tuser_i[0];
  assign item.packet_valid  = s_axis_tuser_i[1];
  assign item.frame_counter = s_axis_tdata_i[7:0];
  assign item.request_id    = s_axis_tdata_i[15:8];
  assign item.rssi_byte     = s_axis_tdata_i[23:16];

  // Configuration registers; an index beyond the list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slot_ms      <= hls_pkg::SLOT_MS_RST;
      cfg_q.lost_wait_ms <= hls_pkg::LOST_WAIT_RST;
      cfg_q.stats_window <= hls_pkg::STATS_WINDOW_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        hls_pkg::REG_SLOT_MS:      cfg_q.slot_ms      <= cfg_wdata_i[7:0];
        hls_pkg::REG_LOST_WAIT_MS: cfg_q.lost_wait_ms <= cfg_wdata_i;
        hls_pkg::REG_STATS_WINDOW: cfg_q.stats_window <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  hls_step #(
    .HopCount(HopCount)
  ) u_step (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .item_i  (item),
    .state_o (state_d),
    .result_o(result_d)
  );

  // Link state moves only when a word is accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.slot_timer  <= hls_pkg::SLOT_TIMER_RST;
      state_q.hop_idx     <= '0;
      state_q.got_packet  <= 1'b0;
      state_q.lost_flag   <= 1'b1;
      state_q.hop_counter <= 8'd0;
      state_q.rx_counter  <= 8'd0;
      state_q.quality     <= 8'd0;
      state_q.rssi        <= hls_pkg::RSSI_RST;
    end else if (in_accept) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload needs no reset; it is qualified by out_valid_q.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(hls_pkg::OutDataW - hls_pkg::ResultW){1'b0}}, result_q};

  // The hop index never leaves the hop table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, state_q.hop_idx} < 7'(HopCount))
    else $error("hop index outside the hop table");

  // A packet report that failed its checks leaves the link state untouched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && s_axis_tuser_i[0] && !s_axis_tuser_i[1] |=> $stable(state_q))
    else $error("rejected packet changed the link state");

  // A lost frame always comes with a hop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_q.frame_lost |-> result_q.hopped)
    else $error("lost frame reported without a hop");

  // Telemetry is only requested by an accepted packet, which brings the link up.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_q.tlm_req |->
      result_q.packet_accepted && !result_q.link_lost)
    else $error("telemetry requested without an accepted packet");

endmodule

[sim/hopping_link_supervisor_tb.sv]
// Self-checking testbench of the hopping link supervisor: random and directed
// words on the input stream, results checked word by word against a predictor.
// Depends on hls_pkg and hopping_link_supervisor only.
module hopping_link_supervisor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any accepted word before the run is declared hung. The
  // longest legitimate quiet stretch is the deliberate receiver hold-off.
  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD   = 80;

  // Predictor of the supervisor. It keeps its own copy of the registers and
  // of the link state, and a queue of result words still to come out.
  class link_predictor;
    logic [7:0]       slot_len;
    logic [15:0]      lost_dwell;
    logic [7:0]       window_len;
    logic [15:0]      timer;
    logic [5:0]       hop;
    logic             got_pkt;
    logic             lost;
    logic [7:0]       hop_cnt;
    logic [7:0]       rx_cnt;
    logic [7:0]       quality;
    logic [7:0]       rssi;
    hls_pkg::result_t due_results[$];
    int               errors;

    function new();
      slot_len   = hls_pkg::SLOT_MS_RST;
      lost_dwell = hls_pkg::LOST_WAIT_RST;
      window_len = hls_pkg::STATS_WINDOW_RST;
      timer      = hls_pkg::SLOT_TIMER_RST;
      hop        = '0;
      got_pkt    = 1'b0;
      lost       = 1'b1;
      hop_cnt    = '0;
      rx_cnt     = '0;
      quality    = '0;
      rssi       = hls_pkg::RSSI_RST;
      errors     = 0;
    endfunction

    function void write_reg(hls_pkg::reg_idx_e idx, logic [15:0] value);
      case (idx)
        hls_pkg::REG_SLOT_MS:      slot_len = value[7:0];
        hls_pkg::REG_LOST_WAIT_MS: lost_dwell = value;
        hls_pkg::REG_STATS_WINDOW: window_len = value[7:0];
        default: ;
      endcase
    endfunction

    function logic [5:0] next_hop(logic [5:0] h);
      int n;
      n = int'(h) + 1;
      if (n >= hls_pkg::HOP_COUNT) n = 0;
      return 6'(n);
    endfunction

    // End of a slot. missed is set when the slot saw no packet, starved when
    // a statistics window closes with no packet at all.
    function void close_slot(output bit missed, output bit starved);
      logic [7:0] old_cnt;
      starved = 1'b0;
      timer   = lost ? lost_dwell : {8'd0, slot_len};
      hop     = next_hop(hop);
      missed  = !got_pkt;
      got_pkt = 1'b0;
      old_cnt = hop_cnt;
      hop_cnt = hop_cnt + 8'd1;
      if (old_cnt >= window_len) begin
        quality = rx_cnt;
        if (rx_cnt == 8'd0) begin
          lost    = 1'b1;
          starved = 1'b1;
        end
        hop_cnt = 8'd1;
        rx_cnt  = 8'd0;
      end
    endfunction

    function void note_word(hls_pkg::item_t w);
      hls_pkg::result_t r;
      logic [5:0]       old_hop;
      bit               missed;
      bit               starved;
      logic [12:0]      scaled;
      logic [7:0]       t;
      r       = '0;
      missed  = 1'b0;
      starved = 1'b0;
      old_hop = hop;
      if (w.cmd == hls_pkg::CMD_TICK) begin
        if (timer != 16'd0) timer = timer - 16'd1;
        if (timer == 16'd0) close_slot(missed, starved);
      end else if (w.packet_valid) begin
        r.packet_accepted = 1'b1;
        r.tlm_req         = (w.frame_counter[1:0] == hls_pkg::TEL_PHASE);
        rx_cnt  = rx_cnt + 8'd1;
        got_pkt = 1'b1;
        lost    = 1'b0;
        scaled  = 13'(w.rssi_byte) * 13'(hls_pkg::RSSI_GAIN);
        t       = 8'(scaled >> hls_pkg::RSSI_SHIFT);
        rssi    = w.rssi_byte[7] ? t - hls_pkg::RSSI_OFS_HI : t + hls_pkg::RSSI_OFS_LO;
        if (r.tlm_req) begin
          r.tlm_id = w.request_id;
          timer = {8'd0, slot_len};
          hop   = next_hop(hop);
        end else begin
          timer = 16'd0;
          close_slot(missed, starved);
        end
      end
      r.current_hop    = hop;
      r.hopped         = (hop != old_hop) || missed || starved;
      r.switch_antenna = missed;
      r.frame_lost     = missed;
      r.enter_failsafe = starved;
      r.link_lost      = lost;
      r.link_quality   = quality;
      r.rssi_out       = rssi;
      due_results.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned seen);
      if (want != seen) begin
        $error("%s: expected %0d, got %0d", name, want, seen);
        errors++;
      end
    endfunction

    function void check_word(logic [hls_pkg::OutDataW-1:0] word);
      hls_pkg::result_t want;
      hls_pkg::result_t seen;
      if (due_results.size() == 0) begin
        $error("result word %h arrived with no expectation waiting", word);
        errors++;
        return;
      end
      want = due_results.pop_front();
      seen = word[hls_pkg::ResultW-1:0];
      compare_field("current_hop", want.current_hop, seen.current_hop);
      compare_field("hopped", want.hopped, seen.hopped);
      compare_field("switch_antenna", want.switch_antenna, seen.switch_antenna);
      compare_field("frame_lost", want.frame_lost, seen.frame_lost);
      compare_field("enter_failsafe", want.enter_failsafe, seen.enter_failsafe);
      compare_field("link_lost", want.link_lost, seen.link_lost);
      compare_field("link_quality", want.link_quality, seen.link_quality);
      compare_field("rssi_out", want.rssi_out, seen.rssi_out);
      compare_field("tlm_req", want.tlm_req, seen.tlm_req);
      compare_field("tlm_id", want.tlm_id, seen.tlm_id);
      compare_field("packet_accepted", want.packet_accepted, seen.packet_accepted);
      compare_field("padding", 0, word[hls_pkg::OutDataW-1:hls_pkg::ResultW]);
    endfunction
  endclass

  // One stretch of random traffic under one register setting. The mix is
  // given in percent: ticks, valid packets, and telemetry among valid ones.
  typedef struct {
    logic [7:0]  slot;
    logic [15:0] dwell;
    logic [7:0]  window;
    int          items;
    int          pct_tick;
    int          pct_valid;
    int          pct_tel;
    bit          gaps;
    bit          hold;
  } phase_t;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_EVERY3, RX_MOSTLY} rx_mode_e;

  logic                         clk_i;
  logic                         rst_n;
  logic                         cfg_we;
  logic [hls_pkg::CfgAddrW-1:0] cfg_addr;
  logic [hls_pkg::CfgDataW-1:0] cfg_wdata;
  logic                         in_valid;
  logic                         in_ready;
  logic [23:0]                  in_data;
  logic [1:0]                   in_user;
  logic                         out_valid;
  logic                         out_ready;
  logic [hls_pkg::OutDataW-1:0] out_data;

  link_predictor pred = new();
  phase_t        plan[7];
  int            burst_left = 0;
  bit            use_gaps = 1'b1;
  int            hold_off = 0;
  int            quiet = 0;

  hopping_link_supervisor uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .s_axis_tuser_i  (in_user),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Both handshakes are observed at the rising edge. The output is checked
  // before the input is noted: a result leaving at this edge always belongs
  // to a word accepted at an earlier edge, so the order cannot matter, but
  // keeping both in one process removes any doubt.
  always @(posedge clk_i) begin
    if (out_valid && out_ready) pred.check_word(out_data);
    if (in_valid && in_ready) begin
      pred.note_word(hls_pkg::item_t'({in_user[0], in_user[1], in_data[7:0],
                                       in_data[15:8], in_data[23:16]}));
    end
  end

  // Watchdog: a run in which no word moves on either side for too long has
  // hung, and is ended as a failure.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver. It stalls on a pattern of its own that changes every so often,
  // and on request holds off for a long stretch so that the output register
  // fills and the input stream is pushed back.
  initial begin
    rx_mode_e mode;
    int       mode_left;
    int       beat;
    mode      = RX_ALWAYS;
    mode_left = 0;
    beat      = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off > 0) begin
        out_ready = 1'b0;
        repeat (hold_off) @(negedge clk_i);
        hold_off = 0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        beat++;
        case (mode)
          RX_ALWAYS: out_ready = 1'b1;
          RX_COIN:   out_ready = 1'($urandom_range(0, 1));
          RX_EVERY3: out_ready = (beat % 3 == 0);
          default:   out_ready = ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  function automatic hls_pkg::item_t make_word(hls_pkg::cmd_e cmd, logic valid,
                                               logic [7:0] fc, logic [7:0] rid,
                                               logic [7:0] raw);
    hls_pkg::item_t w;
    w.cmd           = cmd;
    w.packet_valid  = valid;
    w.frame_counter = fc;
    w.request_id    = rid;
    w.rssi_byte     = raw;
    return w;
  endfunction

  function automatic hls_pkg::item_t random_word(phase_t p);
    hls_pkg::item_t w;
    int             roll;
    w.frame_counter = 8'($urandom_range(0, 255));
    w.request_id    = 8'($urandom_range(0, 255));
    w.rssi_byte     = 8'($urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    if (roll < p.pct_tick) begin
      // Ticks carry random payload and flag bits, which must be ignored.
      w.cmd          = hls_pkg::CMD_TICK;
      w.packet_valid = 1'($urandom_range(0, 1));
    end else begin
      w.cmd          = hls_pkg::CMD_PACKET;
      w.packet_valid = (roll < p.pct_tick + p.pct_valid);
      if (w.packet_valid && $urandom_range(0, 99) < p.pct_tel) begin
        w.frame_counter[1:0] = hls_pkg::TEL_PHASE;
      end
    end
    return w;
  endfunction

  // Offers one word and returns at the falling edge after it was accepted.
  // The sender works in bursts; between bursts it may leave a gap, and
  // sometimes runs straight on so that back-to-back stretches occur too.
  task automatic push_word(input hls_pkg::item_t w);
    if (burst_left == 0) begin
      if (use_gaps && $urandom_range(0, 2) != 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_valid = 1'b1;
    in_data  = {w.rssi_byte, w.request_id, w.frame_counter};
    in_user  = {w.packet_valid, w.cmd};
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
    burst_left--;
  endtask

  // Stops offering and waits until every expected result has come out, then
  // lets the single-stage pipeline go quiet.
  task automatic settle();
    in_valid = 1'b0;
    while (pred.due_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(hls_pkg::reg_idx_e idx, logic [15:0] value);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = value;
    @(negedge clk_i);
    pred.write_reg(idx, value);
  endtask

  initial begin
    hls_pkg::item_t w;
    int             done;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    in_user   = '0;
    rst_n     = 1'b0;

    // slot, dwell, window, items, tick%, valid%, telemetry%, gaps, hold
    plan = '{
      '{8'd3,   16'd5,     8'd4,   200, 60, 30, 30, 1'b1, 1'b0},
      '{8'd1,   16'd1,     8'd1,   200, 90,  6, 40, 1'b1, 1'b0},
      '{8'd255, 16'd65535, 8'd255, 300,  3, 95, 97, 1'b0, 1'b0},
      '{8'd2,   16'd3,     8'd2,   220, 98,  0,  0, 1'b1, 1'b0},
      '{8'd7,   16'd20,    8'd8,   300, 65, 25, 35, 1'b1, 1'b1},
      '{8'd5,   16'd1,     8'd3,   230, 55, 35, 50, 1'b0, 1'b0},
      '{8'd255, 16'd2,     8'd1,   200, 70, 20, 25, 1'b1, 1'b0}
    };

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;
    @(negedge clk_i);

    // Directed part under the reset settings: ticks while lost, an invalid
    // report, the RSSI conversion on both sides of its break point and at
    // the ends of the byte, and every frame counter phase with and without a
    // telemetry request.
    push_word(make_word(hls_pkg::CMD_TICK, 1'b0, 8'h00, 8'h00, 8'h00));
    push_word(make_word(hls_pkg::CMD_TICK, 1'b1, 8'hff, 8'hff, 8'hff));
    push_word(make_word(hls_pkg::CMD_PACKET, 1'b0, 8'd2, 8'hff, 8'hff));
    push_word(make_word(hls_pkg::CMD_PACKET, 1'b1, 8'd0, 8'd0, 8'd0));
    push_word(make_word(hls_pkg::CMD_PACKET, 1'b1, 8'd1, 8'd17, 8'd127));
    push_word(make_word(hls_pkg::CMD_PACKET, 1'b1, 8'd2, 8'd255, 8'd128));
    push_word(make_word(hls_pkg::CMD_PACKET, 1'b1, 8'd3, 8'd170, 8'd255));
    push_word(make_word(hls_pkg::CMD_PACKET, 1'b1, 8'd254, 8'd85, 8'd255));
    repeat (10) push_word(make_word(hls_pkg::CMD_TICK, 1'b0, 8'h00, 8'h00, 8'h00));
    push_word(make_word(hls_pkg::CMD_PACKET, 1'b1, 8'd255, 8'd1, 8'd64));
    push_word(make_word(hls_pkg::CMD_PACKET, 1'b0, 8'd6, 8'd0, 8'd0));
    push_word(make_word(hls_pkg::CMD_PACKET, 1'b1, 8'd6, 8'd200, 8'd200));
    settle();

    foreach (plan[i]) begin
      write_reg(hls_pkg::REG_SLOT_MS, {8'd0, plan[i].slot});
      write_reg(hls_pkg::REG_LOST_WAIT_MS, plan[i].dwell);
      write_reg(hls_pkg::REG_STATS_WINDOW, {8'd0, plan[i].window});
      cfg_we   = 1'b0;
      use_gaps = plan[i].gaps;
      // Long receiver hold-off while the sender keeps offering words.
      if (plan[i].hold) hold_off = LONG_HOLD;
      done = 0;
      while (done < plan[i].items) begin
        w = random_word(plan[i]);
        push_word(w);
        done++;
      end
      // The sender pauses here until every expected result has come.
      settle();
    end

    repeat (8) @(posedge clk_i);
    if (pred.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
